>>> rtl/core/olist_pkg.sv
`timescale 1ns / 1ps
// Package for the ordered list engine: action and status codes, sequencer
// states and the default sizes shared by the interfaces and the engine module.
// No dependencies.
package olist_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int ACTION_W        = 3;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_POP    = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } seq_state_t;

endpackage

>>> rtl/core/olist_cmd_if.sv
`timescale 1ns / 1ps
// Command channel of the ordered list engine: valid/ready plus action and value.
// Depends on olist_pkg.
interface olist_cmd_if #(
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic [olist_pkg::ACTION_W-1:0]     action;
    logic signed [VALUE_WIDTH-1:0]      value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

>>> rtl/core/olist_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the ordered list engine: valid/ready plus list status.
// Depends on olist_pkg.
interface olist_rsp_if #(
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic [olist_pkg::STATUS_W-1:0]     status;
    logic [olist_pkg::COUNT_W-1:0]      entry_total;
    logic                               head_valid;
    logic signed [VALUE_WIDTH-1:0]      head_value;
    logic [olist_pkg::COUNT_W-1:0]      removed_total;

    modport source (output valid, output status, output entry_total, output head_valid,
                    output head_value, output removed_total, input ready);
    modport sink   (input valid, input status, input entry_total, input head_valid,
                    input head_value, input removed_total, output ready);
endinterface

>>> rtl/core/ordered_list_engine.sv
`timescale 1ns / 1ps
// Ordered list engine: bounded list of signed values kept in one RAM and
// walked by a small sequencer. Depends on olist_pkg, olist_cmd_if,
// olist_rsp_if and olist_ram.
// - cmd (sink): one transfer carries an action and a value. Push front,
//   sorted insert, pop front, remove all equal and clear are supported;
//   unused action codes leave the list untouched.
// - rsp (source): exactly one transfer per command, giving status, entry
//   count, head flag and value, and the number of entries removed.
// - Sequence: push, insert, pop and remove walk the RAM once, one entry per
//   cycle (read of entry i+1 overlapped with the write of entry i), then
//   go to the final step, which loads the response into the output register;
//   the next command is taken once the sequencer is back in idle. Clear,
//   unused codes, remove or pop on an empty list and push or insert on a
//   full list go straight to the final step.
// - cmd.ready is high only while the sequencer is idle. A finished response
//   sits in an output register; the next command is still taken while it
//   waits, and the sequencer holds in its final step only if the previous
//   response has not been taken.
// - Reset empties the list at once; no clearing pass over the RAM.
module ordered_list_engine #(
    parameter int CAPACITY    = olist_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    olist_cmd_if.sink   cmd,
    olist_rsp_if.source rsp
);
    import olist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer and list state
    seq_state_t                     state_reg,    state_next;
    logic [CW-1:0]                  count_reg,    count_next;
    action_t                        op_reg,       op_next;
    logic signed [VALUE_WIDTH-1:0]  val_reg,      val_next;
    logic [CW-1:0]                  idx_reg,      idx_next;
    logic [CW-1:0]                  wr_idx_reg,   wr_idx_next;
    logic signed [VALUE_WIDTH-1:0]  hold_reg,     hold_next;
    logic                           shifting_reg, shifting_next;
    logic [CW-1:0]                  removed_reg,  removed_next;
    status_t                        status_reg,   status_next;
    logic signed [VALUE_WIDTH-1:0]  head_reg,     head_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    status_t                        out_status_reg;
    logic [COUNT_W-1:0]             out_total_reg;
    logic                           out_head_valid_reg;
    logic signed [VALUE_WIDTH-1:0]  out_head_reg;
    logic [COUNT_W-1:0]             out_removed_reg;
    logic                           out_load;

    // RAM port
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [VALUE_WIDTH-1:0]         ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [VALUE_WIDTH-1:0]         ram_rdata;
    logic signed [VALUE_WIDTH-1:0]  rd_val;
    logic [CW-1:0]                  idx_inc;
    logic                           walk_end;
    logic                           drop;

    olist_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val   = signed'(ram_rdata);
    assign idx_inc  = idx_reg + CW'(1);
    assign walk_end = (idx_reg == count_reg);
    assign cmd.ready = (state_reg == S_IDLE);

    // While idle keep reading the head slot so entry 0 is ready on the first
    // walk cycle; while walking, fetch the entry after the current one.
    assign ram_raddr = (state_reg == S_WALK) ? idx_inc[AW-1:0] : '0;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        wr_idx_next   = wr_idx_reg;
        hold_next     = hold_reg;
        shifting_next = shifting_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        head_next     = head_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[AW-1:0];
        ram_wdata     = val_reg;
        drop          = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next       = action_t'(cmd.action);
                    val_next      = cmd.value;
                    idx_next      = '0;
                    wr_idx_next   = '0;
                    shifting_next = 1'b0;
                    removed_next  = '0;
                    status_next   = ST_DONE;
                    state_next    = S_FINISH;
                    unique case (action_t'(cmd.action))
                        ACT_PUSH, ACT_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            removed_next = count_reg;
                            count_next   = '0;
                        end
                        default:
                        begin
                            // unused code: report the list unchanged
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                idx_next = idx_inc;
                if (op_reg == ACT_PUSH || op_reg == ACT_INSERT)
                begin
                    // Ripple insert: once the slot is found, every later entry
                    // moves up one place through the hold register.
                    if (walk_end)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = shifting_reg ? hold_reg : val_reg;
                        count_next = count_reg + CW'(1);
                        state_next = S_FINISH;
                    end
                    else if (shifting_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = hold_reg;
                        hold_next = rd_val;
                    end
                    else if (op_reg == ACT_PUSH || val_reg <= rd_val)
                    begin
                        ram_we        = 1'b1;
                        ram_wdata     = val_reg;
                        hold_next     = rd_val;
                        shifting_next = 1'b1;
                    end
                end
                else
                begin
                    // Compaction: drop matching entries, move the rest down.
                    if (walk_end)
                    begin
                        count_next = wr_idx_reg;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        drop = (op_reg == ACT_POP) ? (idx_reg == '0) : (rd_val == val_reg);
                        if (drop)
                        begin
                            removed_next = removed_reg + CW'(1);
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = wr_idx_reg[AW-1:0];
                            ram_wdata   = rd_val;
                            wr_idx_next = wr_idx_reg + CW'(1);
                        end
                    end
                end
                // Track the head so the response needs no extra read.
                if (ram_we && ram_waddr == '0)
                begin
                    head_next = signed'(ram_wdata);
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        wr_idx_reg   <= wr_idx_next;
        hold_reg     <= hold_next;
        shifting_reg <= shifting_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        head_reg     <= head_next;
        if (out_load)
        begin
            out_status_reg     <= status_reg;
            out_total_reg      <= COUNT_W'(count_reg);
            out_head_valid_reg <= (count_reg != '0);
            out_head_reg       <= (count_reg != '0) ? head_reg : '0;
            out_removed_reg    <= COUNT_W'(removed_reg);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_total   = out_total_reg;
    assign rsp.head_valid    = out_head_valid_reg;
    assign rsp.head_value    = out_head_reg;
    assign rsp.removed_total = out_removed_reg;

endmodule

>>> rtl/core/olist_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olist_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
